// ===== src/hcbd_pkg.sv =====
// Package for the chunked body decoder: codes, constants and shared types.
`default_nettype none
package hcbd_pkg;

  // Decoded length saturation ceiling and line terminator characters
  localparam logic [30:0] SIZE_LIMIT = 31'h7fff_ffff;
  localparam logic [7:0]  CH_CR      = 8'h0d;
  localparam logic [7:0]  CH_LF      = 8'h0a;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_EXT     = 3'd1,
    PH_SIZE_LF = 3'd2,
    PH_DATA    = 3'd3,
    PH_DATA_CR = 3'd4,
    PH_DATA_LF = 3'd5
  } phase_t;

  // Sticky decode status codes
  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_DONE    = 3'd1,
    ST_NODIG   = 3'd2,
    ST_OVF     = 3'd3,
    ST_LINE    = 3'd4,
    ST_DATAEND = 3'd5,
    ST_TRUNC   = 3'd6
  } status_t;

  // One result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    status_t     decode_status;
    logic [30:0] decoded_length;
    logic        message_end;
  } result_t;

endpackage
`default_nettype wire

// ===== src/hcbd_in_if.sv =====
// Input channel: raw encoded body bytes with an end-of-body flag.
`default_nettype none
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       final_byte;

  modport source (output valid, output body_byte, output final_byte, input ready);
  modport sink   (input valid, input body_byte, input final_byte, output ready);
endinterface
`default_nettype wire

// ===== src/hcbd_out_if.sv =====
// Output channel: one decode result per input byte.
`default_nettype none
interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [2:0]  decode_status;
  logic [30:0] decoded_length;
  logic        message_end;

  modport source (output valid, output payload_valid, output payload_byte,
                  output decode_status, output decoded_length, output message_end,
                  input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input decode_status, input decoded_length, input message_end,
                  output ready);
endinterface
`default_nettype wire

// ===== src/hcbd_parse.sv =====
// Chunk parser: per-message state and the one-byte state update.
`default_nettype none
module hcbd_parse (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      body_byte,
  input  wire logic            final_byte,
  output hcbd_pkg::result_t    result
);

  hcbd_pkg::phase_t  phase, phase_next;
  hcbd_pkg::status_t status, status_next, status_word;
  logic [30:0]       chunk_remaining, chunk_remaining_next;
  logic              digit_seen, digit_seen_next;
  logic [30:0]       length_count, length_count_next;
  logic              emit;
  logic [7:0]        emit_byte;

  // Hex digit decode, either letter case
  logic       is_hex;
  logic [3:0] hex_val;
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
      hex_val = body_byte[3:0];
    end else if ((body_byte >= 8'h61 && body_byte <= 8'h66) ||
                 (body_byte >= 8'h41 && body_byte <= 8'h46)) begin
      hex_val = body_byte[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Size accumulate; overflow when the shifted sum leaves 31 bits
  logic [34:0] size_acc;
  assign size_acc = {chunk_remaining, 4'b0000} + {31'd0, hex_val};

  logic [30:0] chunk_dec;
  assign chunk_dec = chunk_remaining - 31'd1;

  // Next state for the byte at hand
  always_comb begin
    phase_next           = phase;
    status_next          = status;
    chunk_remaining_next = chunk_remaining;
    digit_seen_next      = digit_seen;
    length_count_next    = length_count;
    emit                 = 1'b0;
    emit_byte            = 8'd0;
    if (status == hcbd_pkg::ST_RUN) begin
      unique case (phase)
        hcbd_pkg::PH_SIZE: begin
          if (is_hex) begin
            if (size_acc[34:31] != 4'd0) begin
              status_next = hcbd_pkg::ST_OVF;
            end else begin
              chunk_remaining_next = size_acc[30:0];
              digit_seen_next      = 1'b1;
            end
          end else if (!digit_seen) begin
            status_next = hcbd_pkg::ST_NODIG;
          end else if (body_byte == hcbd_pkg::CH_CR) begin
            phase_next = hcbd_pkg::PH_SIZE_LF;
          end else if (body_byte == hcbd_pkg::CH_LF) begin
            status_next = hcbd_pkg::ST_LINE;
          end else begin
            phase_next = hcbd_pkg::PH_EXT;
          end
        end
        hcbd_pkg::PH_EXT: begin
          if (body_byte == hcbd_pkg::CH_CR) begin
            phase_next = hcbd_pkg::PH_SIZE_LF;
          end else if (body_byte == hcbd_pkg::CH_LF) begin
            status_next = hcbd_pkg::ST_LINE;
          end
        end
        hcbd_pkg::PH_SIZE_LF: begin
          if (body_byte != hcbd_pkg::CH_LF) begin
            status_next = hcbd_pkg::ST_LINE;
          end else if (chunk_remaining == 31'd0) begin
            status_next = hcbd_pkg::ST_DONE;
          end else begin
            phase_next = hcbd_pkg::PH_DATA;
          end
        end
        hcbd_pkg::PH_DATA: begin
          emit      = 1'b1;
          emit_byte = body_byte;
          if (length_count != hcbd_pkg::SIZE_LIMIT) begin
            length_count_next = length_count + 31'd1;
          end
          chunk_remaining_next = chunk_dec;
          if (chunk_dec == 31'd0) begin
            phase_next = hcbd_pkg::PH_DATA_CR;
          end
        end
        hcbd_pkg::PH_DATA_CR: begin
          if (body_byte == hcbd_pkg::CH_CR) begin
            phase_next = hcbd_pkg::PH_DATA_LF;
          end else begin
            status_next = hcbd_pkg::ST_DATAEND;
          end
        end
        hcbd_pkg::PH_DATA_LF: begin
          if (body_byte == hcbd_pkg::CH_LF) begin
            phase_next           = hcbd_pkg::PH_SIZE;
            chunk_remaining_next = 31'd0;
            digit_seen_next      = 1'b0;
          end else begin
            status_next = hcbd_pkg::ST_DATAEND;
          end
        end
        default: begin
          phase_next = hcbd_pkg::PH_SIZE;
        end
      endcase
    end
  end

  // Still running at end of body means truncated
  assign status_word = (final_byte && status_next == hcbd_pkg::ST_RUN) ?
                       hcbd_pkg::ST_TRUNC : status_next;

  // Result word for this byte
  always_comb begin
    result.payload_valid  = emit;
    result.payload_byte   = emit_byte;
    result.decode_status  = status_word;
    result.decoded_length = length_count_next;
    result.message_end    = final_byte;
  end

  // State registers; end of body restarts the message
  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      phase           <= hcbd_pkg::PH_SIZE;
      status          <= hcbd_pkg::ST_RUN;
      chunk_remaining <= 31'd0;
      digit_seen      <= 1'b0;
      length_count    <= 31'd0;
    end else if (step) begin
      phase           <= phase_next;
      status          <= status_next;
      chunk_remaining <= chunk_remaining_next;
      digit_seen      <= digit_seen_next;
      length_count    <= length_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/http_chunked_body_decoder.sv =====
// Top level: input register, chunk parser and result register.
// A word accepted into the input register passes through the parser into the result register, which drives the output.
// Throughput: one word per cycle unless the output stalls; the parser computes each next state combinationally.
// A stalled output holds its result while one more word waits in the input register.
// Reset (rst, synchronous) empties both registers and returns the parser to the
// start of a message; the byte flagged final also restarts it.
`default_nettype none
module http_chunked_body_decoder (
  input wire logic  clk,
  input wire logic  rst,
  hcbd_in_if.sink   body,
  hcbd_out_if.source result
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_final;
  logic              out_full;
  hcbd_pkg::result_t out_word;
  hcbd_pkg::result_t parse_word;
  logic              out_adv;
  logic              step;

  // Pipeline advance
  assign out_adv    = !out_full || result.ready;
  assign step       = in_full && out_adv;
  assign body.ready = !in_full || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (body.ready) begin
      in_full <= body.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body.ready && body.valid) begin
      in_byte  <= body.body_byte;
      in_final <= body.final_byte;
    end
  end

  hcbd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .body_byte  (in_byte),
    .final_byte (in_final),
    .result     (parse_word)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_adv) begin
      out_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= parse_word;
    end
  end

  assign result.valid          = out_full;
  assign result.payload_valid  = out_word.payload_valid;
  assign result.payload_byte   = out_word.payload_byte;
  assign result.decode_status  = out_word.decode_status;
  assign result.decoded_length = out_word.decoded_length;
  assign result.message_end    = out_word.message_end;

  // Data bytes only come out while the message is still running
  a_payload_running: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_word.payload_valid && !out_word.message_end) |->
      (out_word.decode_status == hcbd_pkg::ST_RUN))
    else $error("payload word with non-running status");

  // Every end-of-body word carries a verdict
  a_end_verdict: assert property (@(posedge clk) disable iff (rst)
    (out_full && out_word.message_end) |-> (out_word.decode_status != hcbd_pkg::ST_RUN))
    else $error("end of body word with running status");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!in_full && !out_full))
    else $error("pipeline not empty after reset");

  // A held input word stays put while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !out_adv) |=> (in_full && $stable(in_byte) && $stable(in_final)))
    else $error("input register lost a word under stall");

endmodule
`default_nettype wire
